[hdl/ffea_pkg.sv]
// Shared types and constants of the first-fit extent allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
package ffea_pkg;

   // Default geometry
   localparam int NUM_BLOCKS_DEF = 1024;
   localparam int NUM_NODES_DEF  = 128;

   // Fixed payload field widths
   localparam int ACTION_W    = 2;
   localparam int NODE_ID_W   = 7;
   localparam int COUNT_W     = 11;
   localparam int STATUS_W    = 2;
   localparam int FIRST_W     = 10;
   localparam int FREE_BLK_W  = 11;
   localparam int FREE_NODE_W = 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC  = 2'd0,
      ACT_FREE   = 2'd1,
      ACT_RESIZE = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_OK      = 2'd0,
      RSP_NO_RUN  = 2'd1,
      RSP_NO_NODE = 2'd2,
      RSP_INVALID = 2'd3
   } status_type;

   // Where the range marker takes its start and length from
   typedef enum logic [1:0] {
      MARK_EXT = 2'd0,
      MARK_OLD = 2'd1,
      MARK_NEW = 2'd2
   } mark_src_type;

   typedef struct packed {
      logic         clear;
      logic         load_req;
      logic         scan_blk;
      logic         scan_node;
      logic         take_ext;
      logic         mark_load;
      mark_src_type mark_src;
      logic         mark_write;
      logic         mark_value;
      logic         commit;
      logic         finish;
      status_type   code;
   } dp_cmd_type;

   typedef struct packed {
      action_type action;
      logic       count_ok;
      logic       node_ok;
      logic       nodes_empty;
      logic       node_used;
      logic       blk_hit;
      logic       blk_end;
      logic       node_hit;
      logic       mark_last;
      logic       clear_last;
      logic       rsp_busy;
   } dp_stat_type;

endpackage

[hdl/ffea_if.sv]
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on ffea_pkg for the payload widths.
interface ffea_req_if;
   import ffea_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [NODE_ID_W-1:0] node_id;
   logic [COUNT_W-1:0]   block_count;

   modport source (output valid, action, node_id, block_count, input ready);
   modport sink   (input valid, action, node_id, block_count, output ready);
endinterface

interface ffea_rsp_if;
   import ffea_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [NODE_ID_W-1:0]   node_out;
   logic [FIRST_W-1:0]     first_block;
   logic [FREE_BLK_W-1:0]  free_blocks;
   logic [FREE_NODE_W-1:0] free_nodes;

   modport source (output valid, status, node_out, first_block, free_blocks, free_nodes,
                   input ready);
   modport sink   (input valid, status, node_out, first_block, free_blocks, free_nodes,
                   output ready);
endinterface

[hdl/ffea_ctrl.sv]
// Sequencing state machine of the extent allocator.
// Drives datapath commands from datapath status; depends on ffea_pkg.
module ffea_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ffea_pkg::dp_stat_type stat,
   output ffea_pkg::dp_cmd_type  cmd
);
   import ffea_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_EVAL,
      S_UNMARK,
      S_BLK_SCAN,
      S_SET_INIT,
      S_SET,
      S_RESTORE,
      S_NODE_SCAN,
      S_COMMIT,
      S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic       ready_ff, ready_in;
   status_type code_ff, code_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            case (stat.action)
               ACT_ALLOC: begin
                  if (!stat.count_ok) begin
                     code_in  = RSP_INVALID;
                     state_in = S_DONE;
                  end else if (stat.nodes_empty) begin
                     code_in  = RSP_NO_NODE;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_BLK_SCAN;
                  end
               end
               ACT_FREE: begin
                  if (stat.node_ok) begin
                     state_in = S_EVAL;
                  end else begin
                     code_in  = RSP_INVALID;
                     state_in = S_DONE;
                  end
               end
               ACT_RESIZE: begin
                  if (stat.node_ok && stat.count_ok) begin
                     state_in = S_EVAL;
                  end else begin
                     code_in  = RSP_INVALID;
                     state_in = S_DONE;
                  end
               end
               default: begin
                  code_in  = RSP_INVALID;
                  state_in = S_DONE;
               end
            endcase
         end
         S_EVAL: begin
            if (!stat.node_used) begin
               code_in  = RSP_INVALID;
               state_in = S_DONE;
            end else begin
               cmd.take_ext  = 1'b1;
               cmd.mark_load = 1'b1;
               cmd.mark_src  = MARK_EXT;
               state_in      = S_UNMARK;
            end
         end
         S_UNMARK: begin
            cmd.mark_write = 1'b1;
            cmd.mark_value = 1'b0;
            if (stat.mark_last)
               state_in = (stat.action == ACT_FREE) ? S_COMMIT : S_BLK_SCAN;
         end
         S_BLK_SCAN: begin
            cmd.scan_blk = 1'b1;
            if (stat.blk_hit) begin
               state_in = S_SET_INIT;
            end else if (stat.blk_end) begin
               code_in = RSP_NO_RUN;
               if (stat.action == ACT_RESIZE) begin
                  cmd.mark_load = 1'b1;
                  cmd.mark_src  = MARK_OLD;
                  state_in      = S_RESTORE;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SET_INIT: begin
            cmd.mark_load = 1'b1;
            cmd.mark_src  = MARK_NEW;
            state_in      = S_SET;
         end
         S_SET: begin
            cmd.mark_write = 1'b1;
            cmd.mark_value = 1'b1;
            if (stat.mark_last)
               state_in = (stat.action == ACT_ALLOC) ? S_NODE_SCAN : S_COMMIT;
         end
         S_RESTORE: begin
            cmd.mark_write = 1'b1;
            cmd.mark_value = 1'b1;
            if (stat.mark_last) state_in = S_DONE;
         end
         S_NODE_SCAN: begin
            cmd.scan_node = 1'b1;
            if (stat.node_hit) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            code_in    = RSP_OK;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.finish = 1'b1;
               cmd.code   = code_ff;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
         code_ff  <= RSP_OK;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         code_ff  <= code_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

[hdl/ffea_dpath.sv]
// Datapath of the extent allocator: bitmaps, extent table, scan and mark counters,
// free counts and the response register. Depends on ffea_pkg.
module ffea_dpath #(
   parameter int NUM_BLOCKS = ffea_pkg::NUM_BLOCKS_DEF,
   parameter int NUM_NODES  = ffea_pkg::NUM_NODES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ffea_pkg::dp_cmd_type              cmd,
   output ffea_pkg::dp_stat_type             stat,
   input  logic [ffea_pkg::ACTION_W-1:0]     req_action,
   input  logic [ffea_pkg::NODE_ID_W-1:0]    req_node_id,
   input  logic [ffea_pkg::COUNT_W-1:0]      req_block_count,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [ffea_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ffea_pkg::NODE_ID_W-1:0]    rsp_node_out,
   output logic [ffea_pkg::FIRST_W-1:0]      rsp_first_block,
   output logic [ffea_pkg::FREE_BLK_W-1:0]   rsp_free_blocks,
   output logic [ffea_pkg::FREE_NODE_W-1:0]  rsp_free_nodes
);
   import ffea_pkg::*;

   localparam int BLK_AW    = $clog2(NUM_BLOCKS);
   localparam int BLK_CW    = $clog2(NUM_BLOCKS + 1);
   localparam int NODE_AW   = $clog2(NUM_NODES);
   localparam int NODE_CW   = $clog2(NUM_NODES + 1);
   localparam int CLR_DEPTH = (NUM_BLOCKS > NUM_NODES) ? NUM_BLOCKS : NUM_NODES;
   localparam int AW        = $clog2(CLR_DEPTH + 1);

   typedef struct packed {
      logic [BLK_AW-1:0] start;
      logic [BLK_CW-1:0] len;
   } extent_type;

   // Storage
   logic       block_map_ff [NUM_BLOCKS];
   logic       node_map_ff  [NUM_NODES];
   extent_type extent_ff    [NUM_NODES];

   // Request
   action_type           req_act_ff;
   logic [NODE_ID_W-1:0] req_node_ff;
   logic [COUNT_W-1:0]   req_cnt_ff;

   // Scan, mark and result state
   logic [AW-1:0]      addr_ff;
   logic               pend_ff;
   logic [AW-1:0]      pend_idx_ff;
   logic [BLK_CW-1:0]  run_ff;
   logic               blk_q_ff;
   logic               node_q_ff;
   extent_type         ext_q_ff;
   extent_type         old_ff;
   logic [NODE_AW-1:0] found_ff;
   logic [BLK_AW-1:0]  first_ff;
   logic [BLK_CW-1:0]  mark_ff;
   logic [BLK_CW-1:0]  rem_ff;
   logic [BLK_CW-1:0]  free_blk_ff, free_blk_in;
   logic [NODE_CW-1:0] free_node_ff, free_node_in;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [NODE_ID_W-1:0]   rsp_node_ff;
   logic [FIRST_W-1:0]     rsp_first_ff;
   logic [FREE_BLK_W-1:0]  rsp_free_blk_ff;
   logic [FREE_NODE_W-1:0] rsp_free_node_ff;

   logic [BLK_CW-1:0]  len_req;
   logic [NODE_AW-1:0] req_node_idx;
   logic [NODE_AW-1:0] sel_node;
   logic [NODE_AW-1:0] node_raddr;
   logic               scanning;
   logic               issue;
   logic [BLK_CW-1:0]  run_inc;
   logic [AW-1:0]      hit_start;
   logic               blk_hit;
   logic               blk_end;
   logic               node_hit;
   logic               node_we;
   logic [NODE_AW-1:0] node_waddr;
   logic               node_wdata;
   logic               clr_blk;
   logic               clr_node;

   assign len_req      = BLK_CW'(req_cnt_ff);
   assign req_node_idx = NODE_AW'(req_node_ff);
   assign sel_node     = (req_act_ff == ACT_ALLOC) ? found_ff : req_node_idx;
   assign node_raddr   = cmd.scan_node ? addr_ff[NODE_AW-1:0] : sel_node;

   // One bitmap entry is read per cycle; the data returns in the following cycle, registered with its index.
   assign scanning  = cmd.scan_blk || cmd.scan_node;
   assign issue     = (cmd.scan_blk && (addr_ff < AW'(NUM_BLOCKS))) ||
                      (cmd.scan_node && (addr_ff < AW'(NUM_NODES)));
   assign run_inc   = run_ff + BLK_CW'(1);
   assign hit_start = pend_idx_ff + AW'(1) - AW'(len_req);
   assign blk_hit   = cmd.scan_blk && pend_ff && !blk_q_ff && (run_inc == len_req);
   assign blk_end   = cmd.scan_blk && pend_ff && !blk_hit &&
                      (pend_idx_ff == AW'(NUM_BLOCKS - 1));
   assign node_hit  = cmd.scan_node && pend_ff && !node_q_ff;

   assign clr_blk  = cmd.clear && (addr_ff < AW'(NUM_BLOCKS));
   assign clr_node = cmd.clear && (addr_ff < AW'(NUM_NODES));

   always_comb begin
      node_we    = 1'b0;
      node_waddr = sel_node;
      node_wdata = 1'b0;
      if (clr_node) begin
         node_we    = 1'b1;
         node_waddr = addr_ff[NODE_AW-1:0];
      end else if (cmd.commit && (req_act_ff == ACT_ALLOC)) begin
         node_we    = 1'b1;
         node_wdata = 1'b1;
      end else if (cmd.commit && (req_act_ff == ACT_FREE)) begin
         node_we = 1'b1;
      end
   end

   always_comb begin
      free_blk_in  = free_blk_ff;
      free_node_in = free_node_ff;
      if (cmd.commit) begin
         case (req_act_ff)
            ACT_ALLOC: begin
               free_blk_in  = free_blk_ff - len_req;
               free_node_in = free_node_ff - NODE_CW'(1);
            end
            ACT_FREE: begin
               free_blk_in  = free_blk_ff + old_ff.len;
               free_node_in = free_node_ff + NODE_CW'(1);
            end
            ACT_RESIZE: free_blk_in = free_blk_ff + old_ff.len - len_req;
            default: ;
         endcase
      end
   end

   // Memories
   always_ff @(posedge clock) begin
      blk_q_ff  <= block_map_ff[addr_ff[BLK_AW-1:0]];
      node_q_ff <= node_map_ff[node_raddr];
      ext_q_ff  <= extent_ff[sel_node];
      if (clr_blk)
         block_map_ff[addr_ff[BLK_AW-1:0]] <= 1'b0;
      else if (cmd.mark_write)
         block_map_ff[mark_ff[BLK_AW-1:0]] <= cmd.mark_value;
      if (node_we)
         node_map_ff[node_waddr] <= node_wdata;
      if (cmd.commit && (req_act_ff != ACT_FREE))
         extent_ff[sel_node] <= '{start: first_ff, len: len_req};
   end

   // Request capture and extent bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_act_ff  <= action_type'(req_action);
         req_node_ff <= req_node_id;
         req_cnt_ff  <= req_block_count;
      end
      if (cmd.take_ext) begin
         old_ff   <= ext_q_ff;
         first_ff <= ext_q_ff.start;
      end else if (blk_hit) begin
         first_ff <= BLK_AW'(hit_start);
      end
      if (node_hit)
         found_ff <= pend_idx_ff[NODE_AW-1:0];
      pend_idx_ff <= addr_ff;
   end

   // Scan pointer: clear sweep, bitmap scans, idle at zero otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         pend_ff <= 1'b0;
         run_ff  <= '0;
      end else if (cmd.clear) begin
         addr_ff <= addr_ff + AW'(1);
      end else if (scanning) begin
         if (issue) addr_ff <= addr_ff + AW'(1);
         pend_ff <= issue;
         if (cmd.scan_blk && pend_ff)
            run_ff <= blk_q_ff ? '0 : run_inc;
      end else begin
         addr_ff <= '0;
         pend_ff <= 1'b0;
         run_ff  <= '0;
      end
   end

   // Range marker
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= '0;
         rem_ff  <= '0;
      end else if (cmd.mark_load) begin
         case (cmd.mark_src)
            MARK_EXT: begin
               mark_ff <= BLK_CW'(ext_q_ff.start);
               rem_ff  <= ext_q_ff.len;
            end
            MARK_OLD: begin
               mark_ff <= BLK_CW'(old_ff.start);
               rem_ff  <= old_ff.len;
            end
            default: begin
               mark_ff <= BLK_CW'(first_ff);
               rem_ff  <= len_req;
            end
         endcase
      end else if (cmd.mark_write) begin
         mark_ff <= mark_ff + BLK_CW'(1);
         rem_ff  <= rem_ff - BLK_CW'(1);
      end
   end

   // Free counts
   always_ff @(posedge clock) begin
      if (reset) begin
         free_blk_ff  <= BLK_CW'(NUM_BLOCKS);
         free_node_ff <= NODE_CW'(NUM_NODES);
      end else begin
         free_blk_ff  <= free_blk_in;
         free_node_ff <= free_node_in;
      end
   end

   // Response register: one beat held until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= cmd.code;
         if ((req_act_ff == ACT_FREE) || (req_act_ff == ACT_RESIZE))
            rsp_node_ff <= req_node_ff;
         else if (cmd.code == RSP_OK)
            rsp_node_ff <= NODE_ID_W'(found_ff);
         else
            rsp_node_ff <= '0;
         rsp_first_ff     <= (cmd.code == RSP_OK) ? FIRST_W'(first_ff) : '0;
         rsp_free_blk_ff  <= FREE_BLK_W'(free_blk_ff);
         rsp_free_node_ff <= FREE_NODE_W'(free_node_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_node_out    = rsp_node_ff;
   assign rsp_first_block = rsp_first_ff;
   assign rsp_free_blocks = rsp_free_blk_ff;
   assign rsp_free_nodes  = rsp_free_node_ff;

   always_comb begin
      stat.action      = req_act_ff;
      stat.count_ok    = (req_cnt_ff != '0) && (32'(req_cnt_ff) <= 32'(NUM_BLOCKS));
      stat.node_ok     = 32'(req_node_ff) < 32'(NUM_NODES);
      stat.nodes_empty = (free_node_ff == '0);
      stat.node_used   = node_q_ff;
      stat.blk_hit     = blk_hit;
      stat.blk_end     = blk_end;
      stat.node_hit    = node_hit;
      stat.mark_last   = (rem_ff == BLK_CW'(1));
      stat.clear_last  = cmd.clear && (addr_ff == AW'(CLR_DEPTH - 1));
      stat.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

`ifndef NO_ASSERTIONS
   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_write |-> (32'(mark_ff) < 32'(NUM_BLOCKS)))
      else $error("range marker wrote past the last block");

   a_free_blk_bound: assert property (@(posedge clock) disable iff (reset)
      32'(free_blk_ff) <= 32'(NUM_BLOCKS))
      else $error("free block count above disk size");

   a_free_node_bound: assert property (@(posedge clock) disable iff (reset)
      32'(free_node_ff) <= 32'(NUM_NODES))
      else $error("free inode count above inode table size");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response loaded over a beat not yet taken");

   a_alloc_node_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (req_act_ff == ACT_ALLOC)) |-> (free_node_ff != '0))
      else $error("inode allocated with no free inode counted");
`endif

endmodule

[hdl/first_fit_extent_allocator.sv]
// Top level of the first-fit contiguous extent allocator.
// Instantiates ffea_ctrl and ffea_dpath; depends on ffea_pkg and the ffea_if interfaces.
//
// Allocator for a simulated disk of NUM_BLOCKS blocks and NUM_NODES inodes. Each request beat
// carries an action (allocate, free, resize), an inode and a block count; each request yields
// exactly one response beat with a status, the inode, the start block and the free block and
// inode counts after the request. Allocate takes the lowest free inode and the lowest-addressed
// run of block_count free blocks; free releases an inode and its extent; resize releases the
// old extent, then first-fits a new run (which may overlap the old one) and keeps the old one
// if nothing fits. Rejected requests leave all state untouched. The block bitmap lives in a
// memory that is walked one block per cycle; after reset a clearing sweep over both bitmaps
// runs with ready low before the first request is taken. A request is first checked (free and
// resize also read the inode bitmap); allocate then scans the block bitmap up to the end of
// the first fitting run, marks its blocks and scans the inode bitmap for the lowest free inode;
// free unmarks the old extent; resize unmarks the old extent, scans and marks the new run.
// With no fitting run the scan covers the whole bitmap and resize marks the old extent back.
// One request is in flight at a time; ready rises in the same cycle that the response is
// loaded, even if that response has not yet been taken downstream. A response still waiting
// downstream holds the next one back, and the block sits ready-low until it can load it.
module first_fit_extent_allocator #(
   parameter int NUM_BLOCKS = ffea_pkg::NUM_BLOCKS_DEF,
   parameter int NUM_NODES  = ffea_pkg::NUM_NODES_DEF
) (
   input logic       clock,
   input logic       reset,
   ffea_req_if.sink  req_bus,
   ffea_rsp_if.source rsp_bus
);
   import ffea_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // Sequencer: owns request acceptance and the order of datapath operations
   ffea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // Datapath: bitmaps, extent table, counters and the response register
   ffea_dpath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .NUM_NODES  (NUM_NODES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .req_action      (req_bus.action),
      .req_node_id     (req_bus.node_id),
      .req_block_count (req_bus.block_count),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_status      (rsp_bus.status),
      .rsp_node_out    (rsp_bus.node_out),
      .rsp_first_block (rsp_bus.first_block),
      .rsp_free_blocks (rsp_bus.free_blocks),
      .rsp_free_nodes  (rsp_bus.free_nodes)
   );

endmodule

[test/first_fit_extent_allocator_test.sv]
// Self-checking testbench for first_fit_extent_allocator: a directed table, then random
// allocate/free/resize traffic under several idle patterns, checked against a local predictor.
// Depends on ffea_pkg and the ffea_req_if / ffea_rsp_if channel interfaces.
`timescale 1ns / 100ps

module first_fit_extent_allocator_test;
   import ffea_pkg::*;

   localparam int NUM_BLOCKS = NUM_BLOCKS_DEF;
   localparam int NUM_NODES  = NUM_NODES_DEF;

   // Action code the block must reject
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // Random beats per idle pattern; the episodes at the head of a phase count too
   localparam int PHASE_BEATS = 130;

   // Worst case is a full-disk resize per beat plus the clearing sweep;
   // allow several times the slowest correct run
   localparam int CYCLE_LIMIT = 8_000_000;

   // Quiet cycles after the last response, to catch stray beats
   localparam int TAIL_CYCLES = 300;

   // One response beat as the allocator reports it
   typedef struct packed {
      status_type             status;
      logic [NODE_ID_W-1:0]   node;
      logic [FIRST_W-1:0]     first;
      logic [FREE_BLK_W-1:0]  free_blk;
      logic [FREE_NODE_W-1:0] free_node;
   } alloc_outcome;

   // Directed stimulus row; typed rows carry their response, the rest use the predictor
   typedef struct packed {
      logic [ACTION_W-1:0]    act;
      logic [NODE_ID_W-1:0]   node;
      logic [COUNT_W-1:0]     cnt;
      logic                   typed;
      status_type             st;
      logic [NODE_ID_W-1:0]   nout;
      logic [FIRST_W-1:0]     first;
      logic [FREE_BLK_W-1:0]  fb;
      logic [FREE_NODE_W-1:0] fn;
   } directed_row;

   logic clock;
   logic reset;

   ffea_req_if req_bus ();
   ffea_rsp_if rsp_bus ();

   first_fit_extent_allocator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predictor copy of the disk: bitmaps, extent table and free counters
   bit blk_used  [NUM_BLOCKS];
   bit node_used [NUM_NODES];
   int ext_start [NUM_NODES];
   int ext_len   [NUM_NODES];
   int blocks_free;
   int nodes_free;

   alloc_outcome outcomes_due[$];

   int error_count = 0;
   int unsigned cycle_count = 0;
   int tx_idle_pct;
   int rx_stall_pct;
   int phase_beats;

   directed_row plan [0:23];

   // 10 ns clock
   always begin
      #5 clock = 1'b0;
      #5 clock = 1'b1;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // Lowest-addressed run of len free blocks, NUM_BLOCKS when nothing fits
   function automatic int find_run(int len);
      int run;
      run = 0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         if (!blk_used[b]) begin
            run++;
            if (run == len) return b + 1 - len;
         end else begin
            run = 0;
         end
      end
      return NUM_BLOCKS;
   endfunction

   function automatic void mark_blocks(int start, int len, bit used);
      for (int b = start; b < start + len && b < NUM_BLOCKS; b++) blk_used[b] = used;
   endfunction

   // Apply one request to the local disk image and return the response it must produce
   function automatic alloc_outcome run_allocator(logic [ACTION_W-1:0] act,
                                                  logic [NODE_ID_W-1:0] node,
                                                  logic [COUNT_W-1:0] cnt);
      alloc_outcome r;
      int n, s, os, olen;
      bit count_ok;
      r.status = RSP_INVALID;
      r.node   = '0;
      r.first  = '0;
      count_ok = (cnt != 0) && (cnt <= NUM_BLOCKS);
      case (act)
         ACT_ALLOC: begin
            if (count_ok) begin
               // check order: inode first, then the run
               n = NUM_NODES;
               for (int i = NUM_NODES - 1; i >= 0; i--) if (!node_used[i]) n = i;
               if (n >= NUM_NODES) begin
                  r.status = RSP_NO_NODE;
               end else begin
                  s = find_run(cnt);
                  if (s >= NUM_BLOCKS) begin
                     r.status = RSP_NO_RUN;
                  end else begin
                     mark_blocks(s, cnt, 1'b1);
                     node_used[n] = 1'b1;
                     ext_start[n] = s;
                     ext_len[n]   = cnt;
                     blocks_free -= cnt;
                     nodes_free  -= 1;
                     r.status = RSP_OK;
                     r.node   = n[NODE_ID_W-1:0];
                     r.first  = s[FIRST_W-1:0];
                  end
               end
            end
         end
         ACT_FREE: begin
            r.node = node;
            if (node_used[node]) begin
               mark_blocks(ext_start[node], ext_len[node], 1'b0);
               node_used[node] = 1'b0;
               blocks_free += ext_len[node];
               nodes_free  += 1;
               r.status = RSP_OK;
               r.first  = ext_start[node][FIRST_W-1:0];
            end
         end
         ACT_RESIZE: begin
            r.node = node;
            if (node_used[node] && count_ok) begin
               // old extent counts as free during the search
               os   = ext_start[node];
               olen = ext_len[node];
               mark_blocks(os, olen, 1'b0);
               s = find_run(cnt);
               if (s >= NUM_BLOCKS) begin
                  mark_blocks(os, olen, 1'b1);
                  r.status = RSP_NO_RUN;
               end else begin
                  mark_blocks(s, cnt, 1'b1);
                  ext_start[node] = s;
                  ext_len[node]   = cnt;
                  blocks_free = blocks_free + olen - cnt;
                  r.status = RSP_OK;
                  r.first  = s[FIRST_W-1:0];
               end
            end
         end
         default: ;
      endcase
      r.free_blk  = blocks_free[FREE_BLK_W-1:0];
      r.free_node = nodes_free[FREE_NODE_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------------

   // Drive one request beat. Enter and leave at a falling edge; idle there at random,
   // then hold the beat until the block takes it and queue the response it owes.
   task automatic send_item(logic [ACTION_W-1:0] act, logic [NODE_ID_W-1:0] node,
                            logic [COUNT_W-1:0] cnt, bit typed = 1'b0,
                            alloc_outcome typed_want = '0);
      alloc_outcome predicted;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= act;
      req_bus.node_id     <= node;
      req_bus.block_count <= cnt;
      do @(posedge clock); while (!req_bus.ready);
      // advance the predictor even for typed rows so later rows see the right disk
      predicted = run_allocator(act, node, cnt);
      outcomes_due.push_back(typed ? typed_want : predicted);
      phase_beats++;
      @(negedge clock);
   endtask

   // Drop valid and hold off until every queued response has been seen
   task automatic settle_outcomes();
      req_bus.valid <= 1'b0;
      while (outcomes_due.size() != 0) @(negedge clock);
   endtask

   // Mostly small extents, a few large ones, the odd invalid count
   function automatic logic [COUNT_W-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return ($urandom_range(0, 1) == 0) ? 11'd0 : 11'($urandom_range(1025, 2047));
      if (r < 80) return 11'($urandom_range(1, 12));
      if (r < 95) return 11'($urandom_range(13, 128));
      return 11'($urandom_range(129, NUM_BLOCKS));
   endfunction

   // Usually a live inode so free/resize do real work; now and then any inode
   function automatic logic [NODE_ID_W-1:0] pick_node();
      int start;
      start = $urandom_range(0, NUM_NODES - 1);
      if (nodes_free != NUM_NODES && $urandom_range(0, 9) != 0)
         for (int k = 0; k < NUM_NODES; k++)
            if (node_used[(start + k) % NUM_NODES])
               return 7'((start + k) % NUM_NODES);
      return 7'(start);
   endfunction

   task automatic send_random();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)      send_item(ACT_ALLOC, 7'($urandom), pick_count());
      else if (pick < 72) send_item(ACT_FREE, pick_node(), 11'($urandom));
      else if (pick < 97) send_item(ACT_RESIZE, pick_node(), pick_count());
      else                send_item(ACT_UNUSED, 7'($urandom), 11'($urandom));
   endtask

   // Free every live inode, leaving an empty disk
   task automatic release_all();
      for (int i = 0; i < NUM_NODES; i++)
         if (node_used[i]) send_item(ACT_FREE, 7'(i), 11'($urandom));
   endtask

   // ---------------------------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------------------------

   task automatic flag_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Stall the response channel at random, changing ready only at falling edges
   always @(negedge clock) rsp_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);

   // Check each accepted response beat against the oldest outstanding expectation
   always @(posedge clock) begin
      alloc_outcome want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (outcomes_due.size() == 0) begin
            flag_mismatch("unexpected beat, status", rsp_bus.status, -1);
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_bus.status != want.status)
               flag_mismatch("status", rsp_bus.status, want.status);
            if (rsp_bus.node_out != want.node)
               flag_mismatch("node_out", rsp_bus.node_out, want.node);
            if (rsp_bus.first_block != want.first)
               flag_mismatch("first_block", rsp_bus.first_block, want.first);
            if (rsp_bus.free_blocks != want.free_blk)
               flag_mismatch("free_blocks", rsp_bus.free_blocks, want.free_blk);
            if (rsp_bus.free_nodes != want.free_node)
               flag_mismatch("free_nodes", rsp_bus.free_nodes, want.free_node);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("first_fit_extent_allocator regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------

   initial begin
      alloc_outcome want;
      int tx_plan [4];
      int rx_plan [4];

      reset = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.action      = '0;
      req_bus.node_id     = '0;
      req_bus.block_count = '0;
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      phase_beats  = 0;

      for (int i = 0; i < NUM_BLOCKS; i++) blk_used[i] = 1'b0;
      for (int i = 0; i < NUM_NODES; i++) begin
         node_used[i] = 1'b0;
         ext_start[i] = 0;
         ext_len[i]   = 0;
      end
      blocks_free = NUM_BLOCKS;
      nodes_free  = NUM_NODES;

      // Idle patterns: none, sender idle, receiver stalling, both
      tx_plan = '{0, 78, 0, 38};
      rx_plan = '{0, 0, 78, 38};

      // act, node, count, typed, status, node_out, first, free_blocks, free_nodes
      plan = '{
         // rejects on an empty disk: zero and oversized counts, unknown action, idle inodes
         '{ACT_ALLOC,  7'd127, 11'd0,    1'b1, RSP_INVALID, 7'd0,   10'd0, 11'd1024, 8'd128},
         '{ACT_ALLOC,  7'd0,   11'd1025, 1'b1, RSP_INVALID, 7'd0,   10'd0, 11'd1024, 8'd128},
         '{ACT_ALLOC,  7'd127, 11'd2047, 1'b1, RSP_INVALID, 7'd0,   10'd0, 11'd1024, 8'd128},
         '{ACT_UNUSED, 7'd127, 11'd2047, 1'b1, RSP_INVALID, 7'd0,   10'd0, 11'd1024, 8'd128},
         '{ACT_FREE,   7'd127, 11'd0,    1'b1, RSP_INVALID, 7'd127, 10'd0, 11'd1024, 8'd128},
         '{ACT_RESIZE, 7'd0,   11'd1,    1'b1, RSP_INVALID, 7'd0,   10'd0, 11'd1024, 8'd128},
         // whole disk in one extent, then no room left
         '{ACT_ALLOC,  7'd127, 11'd1024, 1'b1, RSP_OK,      7'd0,   10'd0, 11'd0,    8'd127},
         '{ACT_ALLOC,  7'd0,   11'd1,    1'b1, RSP_NO_RUN,  7'd0,   10'd0, 11'd0,    8'd127},
         // resize onto its own blocks, bad counts on a live inode
         '{ACT_RESIZE, 7'd0,   11'd1024, 1'b1, RSP_OK,      7'd0,   10'd0, 11'd0,    8'd127},
         '{ACT_RESIZE, 7'd0,   11'd0,    1'b1, RSP_INVALID, 7'd0,   10'd0, 11'd0,    8'd127},
         '{ACT_RESIZE, 7'd0,   11'd2047, 1'b1, RSP_INVALID, 7'd0,   10'd0, 11'd0,    8'd127},
         '{ACT_FREE,   7'd0,   11'd5,    1'b1, RSP_OK,      7'd0,   10'd0, 11'd1024, 8'd128},
         '{ACT_ALLOC,  7'd0,   11'd1,    1'b1, RSP_OK,      7'd0,   10'd0, 11'd1023, 8'd127},
         // build a hole and check first fit lands in it
         '{ACT_ALLOC,  7'd0,   11'd3,    1'b0, RSP_OK,      7'd0,   10'd0, 11'd0,    8'd0},
         '{ACT_ALLOC,  7'd0,   11'd2,    1'b0, RSP_OK,      7'd0,   10'd0, 11'd0,    8'd0},
         '{ACT_FREE,   7'd1,   11'd0,    1'b0, RSP_OK,      7'd0,   10'd0, 11'd0,    8'd0},
         '{ACT_ALLOC,  7'd0,   11'd4,    1'b0, RSP_OK,      7'd0,   10'd0, 11'd0,    8'd0},
         '{ACT_ALLOC,  7'd0,   11'd2,    1'b0, RSP_OK,      7'd0,   10'd0, 11'd0,    8'd0},
         // resize overlapping its old extent, resize with no room
         '{ACT_RESIZE, 7'd2,   11'd3,    1'b0, RSP_OK,      7'd0,   10'd0, 11'd0,    8'd0},
         '{ACT_RESIZE, 7'd0,   11'd1020, 1'b0, RSP_OK,      7'd0,   10'd0, 11'd0,    8'd0},
         '{ACT_ALLOC,  7'd0,   11'd1000, 1'b0, RSP_OK,      7'd0,   10'd0, 11'd0,    8'd0},
         '{ACT_FREE,   7'd3,   11'd0,    1'b0, RSP_OK,      7'd0,   10'd0, 11'd0,    8'd0},
         '{ACT_RESIZE, 7'd1,   11'd2,    1'b0, RSP_OK,      7'd0,   10'd0, 11'd0,    8'd0},
         '{ACT_FREE,   7'd2,   11'd2047, 1'b0, RSP_OK,      7'd0,   10'd0, 11'd0,    8'd0}
      };

      // Hold reset, then release it at a falling edge; the block then runs its clearing sweep with ready low
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table, no idling
      foreach (plan[i]) begin
         want = '{plan[i].st, plan[i].nout, plan[i].first, plan[i].fb, plan[i].fn};
         send_item(plan[i].act, plan[i].node, plan[i].cnt, plan[i].typed, want);
      end
      settle_outcomes();

      for (int ph = 0; ph < 4; ph++) begin
         tx_idle_pct  = tx_plan[ph];
         rx_stall_pct = rx_plan[ph];
         phase_beats  = 0;

         if (ph == 1) begin
            // run out of inodes: empty the disk, fill every inode, then ask for more
            release_all();
            for (int k = 0; k < NUM_NODES + 8 && nodes_free != 0; k++)
               send_item(ACT_ALLOC, 7'($urandom), 11'($urandom_range(1, 3)));
            send_item(ACT_ALLOC, 7'($urandom), 11'd5);
            send_item(ACT_ALLOC, 7'($urandom), 11'd1024);
            // count is checked before the inode
            send_item(ACT_ALLOC, 7'($urandom), 11'd0);
         end else if (ph == 2) begin
            // run out of blocks with inodes to spare
            release_all();
            send_item(ACT_ALLOC, 7'($urandom), 11'd1024);
            send_item(ACT_ALLOC, 7'($urandom), 11'd1);
            send_item(ACT_RESIZE, pick_node(), 11'd600);
            send_item(ACT_ALLOC, 7'($urandom), 11'd425);
            send_item(ACT_ALLOC, 7'($urandom), 11'd424);
         end

         while (phase_beats < PHASE_BEATS) send_random();

         // pause the sender until the block has answered everything
         settle_outcomes();
      end

      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && outcomes_due.size() == 0)
         $display("first_fit_extent_allocator regression: pass");
      else
         $display("first_fit_extent_allocator regression: fail");
      $finish;
   end

endmodule

[filelist.f]
hdl/ffea_pkg.sv
hdl/ffea_if.sv
hdl/ffea_ctrl.sv
hdl/ffea_dpath.sv
hdl/first_fit_extent_allocator.sv
test/first_fit_extent_allocator_test.sv
